// ===== rtl/epp_pkg.sv =====
`default_nettype none

package epp_pkg;

    localparam int LEN_W   = 10;
    localparam int PHASE_W = 32;
    localparam int COORD_W = 11;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int SINE_W  = 16;
    localparam int PROD_W  = 28;
    localparam int POS_W   = 30;
    localparam int NUM_ARMS = 3;

    localparam int CANVAS_WIDTH_DEF     = 2048;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q15_ONE     = 64'd32767;
    localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_ARM1_LEN  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARM2_LEN  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARM3_LEN  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARM1_STEP = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ARM2_STEP = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ARM3_STEP = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_PH  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 4'd7;

    typedef logic [LEN_W-1:0]          t_len;
    typedef logic [PHASE_W-1:0]        t_phase;
    typedef logic [COORD_W-1:0]        t_coord;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [POS_W-1:0]   t_pos;

    localparam t_len   ARM1_LEN_RST  = 10'd600;
    localparam t_len   ARM2_LEN_RST  = 10'd50;
    localparam t_len   ARM3_LEN_RST  = 10'd200;
    localparam t_phase ARM1_STEP_RST = 32'd4295;
    localparam t_phase ARM2_STEP_RST = 32'd858993;
    localparam t_phase ARM3_STEP_RST = 32'd4294967;
    localparam t_phase START_PH_RST  = 32'd1073741824;
    localparam t_len   RADIUS_RST    = 10'd1000;

endpackage

`default_nettype wire

// ===== rtl/epp_sine_rom.sv =====
`default_nettype none

module epp_sine_rom #(
    parameter int SINE_TABLE_DEPTH = epp_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int AW = $clog2(SINE_TABLE_DEPTH + 1)
) (
    input  wire                         i_clk,
    input  wire                         i_en,
    input  wire [AW-1:0]                i_addr0,
    input  wire [AW-1:0]                i_addr1,
    output logic [epp_pkg::SINE_W-1:0]  o_data0,
    output logic [epp_pkg::SINE_W-1:0]  o_data1
);
    import epp_pkg::*;

    typedef logic [SINE_W-1:0] t_tab [0:SINE_TABLE_DEPTH];

    // quarter-wave sine, Q1.15, Taylor series to x^17 in Q.30
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] mag;
        logic signed [63:0] sum;
        logic [63:0] r;
        x   = (64'(i) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
        x2  = (x * x) >> 30;
        mag = x;
        sum = signed'(x);
        mag = ((mag * x2) >> 30) / 64'd6;   sum = sum - signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd20;  sum = sum + signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd42;  sum = sum - signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd72;  sum = sum + signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd110; sum = sum - signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd156; sum = sum + signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd210; sum = sum - signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd272; sum = sum + signed'(mag);
        if (sum < 0) begin
            sum = '0;
        end
        r = ((64'(sum) * Q15_ONE) + (64'd1 << 29)) >> 30;
        return SINE_W'(r);
    endfunction

    function automatic t_tab build_tab();
        t_tab t;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            t[i] = sine_entry(i);
        end
        return t;
    endfunction

    localparam t_tab SINE_TAB = build_tab();

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data0 <= SINE_TAB[i_addr0];
            o_data1 <= SINE_TAB[i_addr1];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/epp_arm.sv =====
`default_nettype none

module epp_arm #(
    parameter int SINE_TABLE_DEPTH = epp_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  epp_pkg::t_phase      i_angle,
    input  epp_pkg::t_len        i_len,
    output epp_pkg::t_prod       o_cos_prod,
    output epp_pkg::t_prod       o_sin_prod
);
    import epp_pkg::*;

    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);

    t_phase          w_cos_ang;
    logic [AW-1:0]   w_addr_c;
    logic [AW-1:0]   w_addr_s;
    logic [SINE_W-1:0] w_mag_c;
    logic [SINE_W-1:0] w_mag_s;
    logic            r_neg_c;
    logic            r_neg_s;
    logic signed [SINE_W:0] w_val_c;
    logic signed [SINE_W:0] w_val_s;

    function automatic logic [AW-1:0] rom_addr(input t_phase a);
        logic [63:0]   t;
        logic [AW-1:0] idx;
        t   = 64'(a[29:0]) * 64'(SINE_TABLE_DEPTH) + (64'd1 << 29);
        idx = AW'(t >> 30);
        return a[30] ? (AW'(SINE_TABLE_DEPTH) - idx) : idx;
    endfunction

    assign w_cos_ang = i_angle + QUARTER_TURN;
    assign w_addr_c  = rom_addr(w_cos_ang);
    assign w_addr_s  = rom_addr(i_angle);

    epp_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .AW               (AW)
    ) u_rom (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_addr0 (w_addr_c),
        .i_addr1 (w_addr_s),
        .o_data0 (w_mag_c),
        .o_data1 (w_mag_s)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_c <= w_cos_ang[31];
            r_neg_s <= i_angle[31];
        end
    end

    assign w_val_c = r_neg_c ? -$signed({1'b0, w_mag_c}) : $signed({1'b0, w_mag_c});
    assign w_val_s = r_neg_s ? -$signed({1'b0, w_mag_s}) : $signed({1'b0, w_mag_s});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos_prod <= PROD_W'($signed({1'b0, i_len}) * w_val_c);
            o_sin_prod <= PROD_W'($signed({1'b0, i_len}) * w_val_s);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/three_arm_epicycle_pen_plotter.sv =====
// Three-arm epicycle pen plotter.
// Input channel (i_valid/o_ready): one word is one time tick; i_restart
// clears the three arm phases before that tick is used.
// Output channel (o_valid/i_ready): one word per tick, the three pen tip
// coordinates and o_out_of_bounds (coordinates zero, phases held).
// Config channel (i_cfg_valid/o_cfg_ready): register index and data, always
// ready; write only while no tick is in flight.
// Throughput: one tick per cycle while the receiver keeps up. A tick
// passes through the angle register, sine ROM read, arm products, chained
// pen sums and rounded output register. The phase accumulators update in the
// cycle a tick is taken, so back-to-back ticks see consecutive phases.
// Reset clears the phases and the pipeline valid flags and loads the
// default arm lengths, steps, start phase and canvas radius.
// When the receiver stalls, the whole pipeline holds; o_ready drops only
// while a result is waiting at the output.
`default_nettype none

module three_arm_epicycle_pen_plotter #(
    parameter int CANVAS_WIDTH     = epp_pkg::CANVAS_WIDTH_DEF,
    parameter int SINE_TABLE_DEPTH = epp_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire                              i_restart,
    output logic                             o_valid,
    input  wire                              i_ready,
    output epp_pkg::t_coord                  o_pen1_x,
    output epp_pkg::t_coord                  o_pen1_y,
    output epp_pkg::t_coord                  o_pen2_x,
    output epp_pkg::t_coord                  o_pen2_y,
    output epp_pkg::t_coord                  o_pen3_x,
    output epp_pkg::t_coord                  o_pen3_y,
    output logic                             o_out_of_bounds,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [epp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [epp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import epp_pkg::*;

    localparam int NSTG = 5;

    t_len   r_len   [NUM_ARMS];
    t_phase r_step  [NUM_ARMS];
    t_phase r_start;
    t_len   r_radius;
    t_phase r_phase [NUM_ARMS];
    t_phase n_phase [NUM_ARMS];
    t_phase w_used  [NUM_ARMS];

    logic [NSTG-1:0] r_v;
    logic [NSTG-2:0] r_oob;
    logic            w_en;
    logic            w_accept;
    logic            w_oob;
    logic [LEN_W+1:0] w_len_sum;

    t_phase r_ang   [NUM_ARMS];
    t_prod  w_cprod [NUM_ARMS];
    t_prod  w_sprod [NUM_ARMS];
    t_pos   r_px    [NUM_ARMS];
    t_pos   r_py    [NUM_ARMS];
    t_pos   w_ctr;

    assign o_cfg_ready = 1'b1;
    assign w_en        = !r_v[NSTG-1] || i_ready;
    assign o_ready     = w_en;
    assign w_accept    = i_valid && w_en;
    assign o_valid     = r_v[NSTG-1];

    assign w_len_sum = (LEN_W+2)'(r_len[0]) + (LEN_W+2)'(r_len[1]) + (LEN_W+2)'(r_len[2]);
    assign w_oob     = w_len_sum >= (LEN_W+2)'(r_radius);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len[0]  <= ARM1_LEN_RST;
            r_len[1]  <= ARM2_LEN_RST;
            r_len[2]  <= ARM3_LEN_RST;
            r_step[0] <= ARM1_STEP_RST;
            r_step[1] <= ARM2_STEP_RST;
            r_step[2] <= ARM3_STEP_RST;
            r_start   <= START_PH_RST;
            r_radius  <= RADIUS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ARM1_LEN:  r_len[0]  <= i_cfg_data[LEN_W-1:0];
                REG_ARM2_LEN:  r_len[1]  <= i_cfg_data[LEN_W-1:0];
                REG_ARM3_LEN:  r_len[2]  <= i_cfg_data[LEN_W-1:0];
                REG_ARM1_STEP: r_step[0] <= i_cfg_data;
                REG_ARM2_STEP: r_step[1] <= i_cfg_data;
                REG_ARM3_STEP: r_step[2] <= i_cfg_data;
                REG_START_PH:  r_start   <= i_cfg_data;
                REG_RADIUS:    r_radius  <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_ARMS; k++) begin
            w_used[k]  = i_restart ? '0 : r_phase[k];
            n_phase[k] = w_oob ? w_used[k] : w_used[k] + r_step[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_ARMS; k++) begin
                r_phase[k] <= '0;
            end
        end else if (w_accept) begin
            for (int k = 0; k < NUM_ARMS; k++) begin
                r_phase[k] <= n_phase[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_oob <= {r_oob[NSTG-3:0], w_oob};
            for (int k = 0; k < NUM_ARMS; k++) begin
                r_ang[k] <= w_used[k] + r_start;
            end
        end
    end

    for (genvar g = 0; g < NUM_ARMS; g++) begin : g_arm
        epp_arm #(
            .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
        ) u_arm (
            .i_clk      (i_clk),
            .i_en       (w_en),
            .i_angle    (r_ang[g]),
            .i_len      (r_len[g]),
            .o_cos_prod (w_cprod[g]),
            .o_sin_prod (w_sprod[g])
        );
    end

    assign w_ctr = t_pos'({r_radius, 15'b0});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px[0] <= w_ctr + POS_W'(w_cprod[0]);
            r_py[0] <= w_ctr + POS_W'(w_sprod[0]);
            r_px[1] <= w_ctr + POS_W'(w_cprod[0]) + POS_W'(w_cprod[1]);
            r_py[1] <= w_ctr + POS_W'(w_sprod[0]) + POS_W'(w_sprod[1]);
            r_px[2] <= w_ctr + POS_W'(w_cprod[0]) + POS_W'(w_cprod[1])
                       + POS_W'(w_cprod[2]);
            r_py[2] <= w_ctr + POS_W'(w_sprod[0]) + POS_W'(w_sprod[1])
                       + POS_W'(w_sprod[2]);
        end
    end

    // round half up to whole pixels, clamp to the canvas
    function automatic t_coord to_pixel(input t_pos pos, input logic oob);
        logic signed [POS_W:0] t;
        logic [POS_W-15:0]     p;
        t = {pos[POS_W-1], pos} + (POS_W+1)'(16384);
        p = t[POS_W:15];
        if (oob || pos < 0) begin
            return '0;
        end
        if (32'(p) >= CANVAS_WIDTH) begin
            return COORD_W'(CANVAS_WIDTH - 1);
        end
        return p[COORD_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_pen1_x        <= to_pixel(r_px[0], r_oob[NSTG-2]);
            o_pen1_y        <= to_pixel(r_py[0], r_oob[NSTG-2]);
            o_pen2_x        <= to_pixel(r_px[1], r_oob[NSTG-2]);
            o_pen2_y        <= to_pixel(r_py[1], r_oob[NSTG-2]);
            o_pen3_x        <= to_pixel(r_px[2], r_oob[NSTG-2]);
            o_pen3_y        <= to_pixel(r_py[2], r_oob[NSTG-2]);
            o_out_of_bounds <= r_oob[NSTG-2];
        end
    end

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result waiting");

    a_oob_holds_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_oob && !i_restart) |=>
            (r_phase[0] == $past(r_phase[0]) && r_phase[1] == $past(r_phase[1])
             && r_phase[2] == $past(r_phase[2])))
        else $error("phase advanced while out of bounds");

    a_oob_zero_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_bounds) |->
            (o_pen1_x == '0 && o_pen1_y == '0 && o_pen2_x == '0 && o_pen2_y == '0
             && o_pen3_x == '0 && o_pen3_y == '0))
        else $error("nonzero coordinates on out-of-bounds result");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_restart) |=>
            (r_phase[0] == ($past(w_oob) ? '0 : $past(r_step[0]))))
        else $error("restart did not clear the phase");

endmodule

`default_nettype wire

// ===== sim/tb_three_arm_epicycle_pen_plotter.sv =====
module tb_three_arm_epicycle_pen_plotter;
    timeunit 1ns;
    timeprecision 1ps;

    import epp_pkg::*;

    localparam int DEPTH          = SINE_TABLE_DEPTH_DEF;
    localparam int CANVAS         = CANVAS_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_TICKS    = 160;

    typedef struct packed {
        t_coord pen1_x;
        t_coord pen1_y;
        t_coord pen2_x;
        t_coord pen2_y;
        t_coord pen3_x;
        t_coord pen3_y;
        logic   out_of_bounds;
    } t_pen_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_restart = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    t_coord                o_pen1_x, o_pen1_y, o_pen2_x, o_pen2_y, o_pen3_x, o_pen3_y;
    logic                  o_out_of_bounds;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    three_arm_epicycle_pen_plotter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_restart       (i_restart),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pen1_x        (o_pen1_x),
        .o_pen1_y        (o_pen1_y),
        .o_pen2_x        (o_pen2_x),
        .o_pen2_y        (o_pen2_y),
        .o_pen3_x        (o_pen3_x),
        .o_pen3_y        (o_pen3_y),
        .o_out_of_bounds (o_out_of_bounds),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // plotter model state
    int     sine_lut [0:DEPTH];
    t_len   arm_len [3];
    t_phase arm_step [3];
    t_phase arm_phase [3];
    t_phase start_ph;
    t_len   radius;

    bit        tick_q [$];
    t_pen_word pen_expect_q [$];
    bit        tick_fire = 1'b0;
    int        ticks_fed = 0;
    int        ticks_taken = 0;
    int        cfg_writes = 0;
    int        stall_cycles = 0;
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    function automatic int sine_entry(longint unsigned i);
        longint unsigned x, x2, mag, n;
        longint          sum;
        x   = (i * HALF_PI_Q30) / DEPTH;
        x2  = (x * x) >> 30;
        mag = x;
        sum = longint'(x);
        for (n = 1; n <= 8; n++) begin
            mag = ((mag * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n[0])
                sum -= longint'(mag);
            else
                sum += longint'(mag);
        end
        if (sum < 0)
            sum = 0;
        return int'(($unsigned(sum) * Q15_ONE + (64'd1 << 29)) >> 30);
    endfunction

    function automatic int lut_sine(t_phase a);
        longint unsigned idx;
        int              v;
        idx = a[29:0];
        idx = (idx * DEPTH + (64'd1 << 29)) >> 30;
        if (idx > DEPTH)
            idx = DEPTH;
        v = a[30] ? sine_lut[DEPTH - idx] : sine_lut[idx];
        return a[31] ? -v : v;
    endfunction

    function automatic t_coord q15_to_pixel(longint q);
        longint p;
        if (q < 0)
            return '0;
        p = (q + (longint'(1) << 14)) >>> 15;
        if (p >= CANVAS)
            p = CANVAS - 1;
        return p[COORD_W-1:0];
    endfunction

    function automatic t_pen_word predict_pens(bit restart);
        t_pen_word w;
        longint    px, py;
        t_phase    ang;
        t_coord    tip [6];
        if (restart)
            arm_phase = '{default: '0};
        w = '0;
        if (int'(arm_len[0]) + int'(arm_len[1]) + int'(arm_len[2]) >= int'(radius)) begin
            w.out_of_bounds = 1'b1;
            return w;
        end
        px = longint'(radius) * 32768;
        py = px;
        for (int k = 0; k < NUM_ARMS; k++) begin
            ang = arm_phase[k] + start_ph;
            px += longint'(arm_len[k]) * lut_sine(ang + QUARTER_TURN);
            py += longint'(arm_len[k]) * lut_sine(ang);
            tip[2*k]   = q15_to_pixel(px);
            tip[2*k+1] = q15_to_pixel(py);
        end
        w.pen1_x = tip[0];
        w.pen1_y = tip[1];
        w.pen2_x = tip[2];
        w.pen2_y = tip[3];
        w.pen3_x = tip[4];
        w.pen3_y = tip[5];
        for (int k = 0; k < NUM_ARMS; k++)
            arm_phase[k] += arm_step[k];
        return w;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // sender and receiver
    always @(negedge i_clk) begin
        if (!i_valid || tick_fire) begin
            if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid   <= 1'b1;
                i_restart <= tick_q.pop_front();
            end else begin
                i_valid   <= 1'b0;
                i_restart <= 1'($urandom);
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // model update, result check, watchdog
    always @(posedge i_clk) begin
        t_pen_word want;
        bit        out_fire;
        bit        cfg_fire;
        tick_fire = i_valid && o_ready;
        out_fire  = o_valid && i_ready;
        cfg_fire  = i_cfg_valid && o_cfg_ready;
        if (!i_rst_n) begin
            tick_fire    = 1'b0;
            arm_phase    = '{default: '0};
            arm_len      = '{ARM1_LEN_RST, ARM2_LEN_RST, ARM3_LEN_RST};
            arm_step     = '{ARM1_STEP_RST, ARM2_STEP_RST, ARM3_STEP_RST};
            start_ph     = START_PH_RST;
            radius       = RADIUS_RST;
            stall_cycles = 0;
        end else begin
            if (cfg_fire) begin
                case (i_cfg_index)
                    REG_ARM1_LEN:  arm_len[0] = i_cfg_data[LEN_W-1:0];
                    REG_ARM2_LEN:  arm_len[1] = i_cfg_data[LEN_W-1:0];
                    REG_ARM3_LEN:  arm_len[2] = i_cfg_data[LEN_W-1:0];
                    REG_ARM1_STEP: arm_step[0] = i_cfg_data;
                    REG_ARM2_STEP: arm_step[1] = i_cfg_data;
                    REG_ARM3_STEP: arm_step[2] = i_cfg_data;
                    REG_START_PH:  start_ph = i_cfg_data;
                    REG_RADIUS:    radius = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
                cfg_writes++;
            end
            if (tick_fire) begin
                pen_expect_q.push_back(predict_pens(i_restart));
                ticks_taken++;
            end
            if (out_fire) begin
                if (pen_expect_q.size() == 0) begin
                    $error("result word with no tick pending");
                    mismatches++;
                end else begin
                    want = pen_expect_q.pop_front();
                    check_field("pen1_x", want.pen1_x, o_pen1_x);
                    check_field("pen1_y", want.pen1_y, o_pen1_y);
                    check_field("pen2_x", want.pen2_x, o_pen2_x);
                    check_field("pen2_y", want.pen2_y, o_pen2_y);
                    check_field("pen3_x", want.pen3_x, o_pen3_x);
                    check_field("pen3_y", want.pen3_y, o_pen3_y);
                    check_field("out_of_bounds", want.out_of_bounds, o_out_of_bounds);
                end
            end
            if (tick_fire || out_fire || cfg_fire)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        int seen;
        seen = cfg_writes;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (cfg_writes == seen);
        i_cfg_valid <= 1'b0;
    endtask

    // length and radius registers carry random upper bits, which the block must drop
    task automatic write_all(input int l1, input int l2, input int l3, input t_phase s1,
                             input t_phase s2, input t_phase s3, input t_phase sp,
                             input int r);
        logic [CFG_DATA_W-1:0] hi;
        hi = $urandom & ~32'h3FF;
        write_reg(REG_ARM1_LEN, hi | l1);
        write_reg(REG_ARM2_LEN, ($urandom & ~32'h3FF) | l2);
        write_reg(REG_ARM3_LEN, ($urandom & ~32'h3FF) | l3);
        write_reg(REG_ARM1_STEP, s1);
        write_reg(REG_ARM2_STEP, s2);
        write_reg(REG_ARM3_STEP, s3);
        write_reg(REG_START_PH, sp);
        write_reg(REG_RADIUS, ($urandom & ~32'h3FF) | r);
    endtask

    task automatic feed_pattern(input int n, input logic [31:0] restarts);
        @(posedge i_clk);
        for (int i = 0; i < n; i++)
            tick_q.push_back(restarts[i]);
        ticks_fed += n;
    endtask

    task automatic feed_random(input int n);
        @(posedge i_clk);
        repeat (n) tick_q.push_back($urandom_range(99) < 4);
        ticks_fed += n;
    endtask

    task automatic drain_ticks();
        while (ticks_taken != ticks_fed || pen_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_phase random_phase();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(0, 1 << 22);
            2:       return (t_phase'($urandom_range(3)) << 30) ^ $urandom_range(0, 1 << 20);
            default: return -t_phase'($urandom_range(1, 1 << 22));
        endcase
    endfunction

    function automatic logic [CFG_IDX_W-1:0] unused_index();
        return CFG_IDX_W'($urandom_range(int'(REG_RADIUS) + 1, (1 << CFG_IDX_W) - 1));
    endfunction

    initial begin
        int r, rem, rot, n1;
        int lens [3];
        for (int i = 0; i <= DEPTH; i++)
            sine_lut[i] = sine_entry(i);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, one restart in the middle
        feed_pattern(6, 32'b00_1000);
        drain_ticks();

        // quarter, half and three-quarter turn steps: exact quadrant boundaries, max radius
        write_all(300, 300, 300, QUARTER_TURN, 32'h8000_0000, 32'hC000_0000, '0, 1023);
        feed_pattern(5, 32'b0_0001);
        drain_ticks();

        // zero lengths: radius 0 is out of bounds, radius 1 is not
        write_all(0, 0, 0, '1, '1, '1, '1, 0);
        feed_pattern(3, 32'b010);
        drain_ticks();
        write_reg(REG_RADIUS, 1);
        feed_pattern(2, 32'b00);
        drain_ticks();

        // longest arm in bounds, steps on the table rounding edge
        write_all(1022, 0, 0, 32'd1 << 19, (32'd1 << 19) - 1, 32'd1 << 20, '0, 1023);
        feed_pattern(4, 32'b0001);
        drain_ticks();
        write_reg(unused_index(), $urandom);
        write_reg(unused_index(), $urandom);
        feed_pattern(1, 32'b0);
        drain_ticks();

        // lengths at max, then sum exactly at the radius
        write_all(1023, 1023, 1023, $urandom, $urandom, $urandom, $urandom, 1023);
        feed_pattern(2, 32'b00);
        drain_ticks();
        write_all(341, 341, 341, $urandom, $urandom, $urandom, $urandom, 1023);
        feed_pattern(2, 32'b10);
        drain_ticks();

        for (int p = 0; p < RAND_PHASES; p++) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            r = $urandom_range(1023);
            if (r > 0 && $urandom_range(99) < 85) begin
                rem = r - 1;
                for (int k = 0; k < 3; k++) begin
                    lens[k] = $urandom_range(rem);
                    rem -= lens[k];
                end
            end else begin
                for (int k = 0; k < 3; k++)
                    lens[k] = $urandom_range(1023);
            end
            rot = $urandom_range(2);
            write_all(lens[rot], lens[(rot + 1) % 3], lens[(rot + 2) % 3],
                      random_phase(), random_phase(), random_phase(), random_phase(), r);
            if ($urandom_range(99) < 15)
                write_reg(unused_index(), $urandom);
            case (p % 4)
                1: send_idle_pct = 49;
                2: recv_stall_pct = 49;
                3: begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 14;
                end
                default: ;
            endcase
            n1 = $urandom_range(40, 120);
            feed_random(n1);
            // sender holds off until the pipeline is empty
            drain_ticks();
            feed_random(PHASE_TICKS - n1);
            drain_ticks();
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
